FILE: rtl/gsm3_pkg.sv
package gsm3_pkg;

    localparam int MAX_DIM_DEF   = 64;
    localparam int COEF_BITS_DEF = 16;
    localparam int RADIUS        = 3;
    localparam int TAPS          = 2 * RADIUS + 1;
    localparam int CFG_W         = 7;
    localparam int IDX_W         = 2;
    localparam int SIZE_RESET    = 64;
    localparam int PIX_W         = 8;
    localparam int WORD_W        = 2 * PIX_W;

    typedef enum logic [IDX_W-1:0] {
        REG_SIZE_X = 2'd0,
        REG_SIZE_Y = 2'd1,
        REG_SIZE_Z = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] voxel_in;
        logic             pad;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] voxel_out;
        logic             last;
    } out_word_t;

    // gaussian weights, sigma 1, scaled by 1e5, center first
    localparam longint COEF_E5 [4] = '{39894, 24197, 5399, 443};

    function automatic longint coef_fix(input int k, input int bits);
        longint scaled;
        scaled = COEF_E5[k] * (longint'(1) << bits);
        return (scaled + 50000) / 100000;
    endfunction

endpackage

FILE: rtl/gsm3_ram.sv
module gsm3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/gsm3_cell.sv
module gsm3_cell #(
    parameter int DEPTH = 64,
    parameter int LEN_W = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        wr,
    input  logic                        clear,
    input  logic [LEN_W-1:0]            len,
    input  logic [gsm3_pkg::WORD_W-1:0] wdata,
    output logic [gsm3_pkg::WORD_W-1:0] rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [AW-1:0]    ptr_reg;
    logic [AW-1:0]    ptr_next;
    logic [LEN_W-1:0] len_m1;

    assign len_m1 = len - LEN_W'(1);

    always_comb
    begin
        ptr_next = ptr_reg;
        if (clear)
        begin
            ptr_next = '0;
        end
        else if (wr)
        begin
            if (LEN_W'(ptr_reg) == len_m1)
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    gsm3_ram #(
        .WIDTH (gsm3_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr),
        .waddr (ptr_reg),
        .wdata (wdata),
        .re    (en),
        .raddr (ptr_reg),
        .rdata (rdata)
    );

endmodule

FILE: rtl/gsm3_chain.sv
module gsm3_chain #(
    parameter int DEPTH = 64,
    parameter int LEN_W = 7
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             en,
    input  logic                                             clear,
    input  logic [LEN_W-1:0]                                 len,
    input  logic                                             vld,
    input  logic [gsm3_pkg::WORD_W-1:0]                      din,
    output logic [gsm3_pkg::TAPS-1:0][gsm3_pkg::WORD_W-1:0]  taps
);

    localparam int N = gsm3_pkg::TAPS - 1;

    logic [gsm3_pkg::WORD_W-1:0] treg [1:N][0:N-1];
    logic [gsm3_pkg::WORD_W-1:0] rd   [0:N];
    logic [gsm3_pkg::WORD_W-1:0] view [0:N][0:N];
    logic                        vld_reg [1:N];
    logic                        vldv [0:N];

    assign rd[0]   = din;
    assign vldv[0] = vld;

    genvar k, i;
    generate
        for (k = 1; k <= N; k++)
        begin : g_vld
            assign vldv[k] = vld_reg[k];
        end

        for (k = 0; k <= N; k++)
        begin : g_view
            for (i = 0; i <= N; i++)
            begin : g_tap
                if (i < k)
                begin : g_old
                    assign view[k][i] = treg[k][i];
                end
                else
                begin : g_new
                    assign view[k][i] = rd[k];
                end
            end
        end

        for (k = 1; k <= N; k++)
        begin : g_cell
            gsm3_cell #(
                .DEPTH (DEPTH),
                .LEN_W (LEN_W)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (en),
                .wr    (en && vldv[k-1]),
                .clear (clear),
                .len   (len),
                .wdata (view[k-1][k-1]),
                .rdata (rd[k])
            );
        end

        for (i = 0; i <= N; i++)
        begin : g_out
            assign taps[i] = view[N][i];
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 1; s <= N; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int s = 1; s <= N; s++)
            begin
                vld_reg[s] <= vldv[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 1; s <= N; s++)
            begin
                for (int j = 0; j < N; j++)
                begin
                    treg[s][j] <= view[s-1][j];
                end
            end
        end
    end

endmodule

FILE: rtl/gsm3_pass.sv
module gsm3_pass #(
    parameter int DIM_W     = 7,
    parameter int COEF_BITS = gsm3_pkg::COEF_BITS_DEF
) (
    input  logic                                            clk,
    input  logic                                            en,
    input  logic [gsm3_pkg::TAPS-1:0][gsm3_pkg::PIX_W-1:0]  taps,
    input  logic [DIM_W-1:0]                                pos,
    input  logic [DIM_W-1:0]                                size,
    output logic [gsm3_pkg::PIX_W-1:0]                      res
);

    localparam int PROD_W = gsm3_pkg::PIX_W + COEF_BITS;
    localparam int SUM_W  = PROD_W + 3;
    localparam logic [COEF_BITS-1:0] COEF [4] = '{
        COEF_BITS'(gsm3_pkg::coef_fix(0, COEF_BITS)),
        COEF_BITS'(gsm3_pkg::coef_fix(1, COEF_BITS)),
        COEF_BITS'(gsm3_pkg::coef_fix(2, COEF_BITS)),
        COEF_BITS'(gsm3_pkg::coef_fix(3, COEF_BITS))
    };

    logic [PROD_W-1:0]          prod_reg [gsm3_pkg::TAPS];
    logic [PROD_W-1:0]          prod_next [gsm3_pkg::TAPS];
    logic [SUM_W-1:0]           sum;
    logic [gsm3_pkg::PIX_W-1:0] res_reg;

    // tap k sits at offset radius-k from the center
    always_comb
    begin
        for (int k = 0; k < gsm3_pkg::TAPS; k++)
        begin
            if ((int'(pos) + gsm3_pkg::RADIUS >= k)
                && (int'(pos) + gsm3_pkg::RADIUS < int'(size) + k))
            begin
                prod_next[k] = PROD_W'(COEF[(k > gsm3_pkg::RADIUS)
                                            ? (k - gsm3_pkg::RADIUS)
                                            : (gsm3_pkg::RADIUS - k)])
                               * PROD_W'(taps[k]);
            end
            else
            begin
                prod_next[k] = '0;
            end
        end
    end

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < gsm3_pkg::TAPS; k++)
        begin
            sum = sum + SUM_W'(prod_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < gsm3_pkg::TAPS; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            res_reg <= sum[COEF_BITS +: gsm3_pkg::PIX_W];
        end
    end

    assign res = res_reg;

endmodule

FILE: rtl/gaussian_smooth_max_3d.sv
// Streaming 3-D 7-tap Gaussian smoother: voxels enter x fastest, one word per
// clock unless the output stalls, and each result is max(original, smoothed).
// Passes along x, y and z run back to back; the y and z passes read chains of
// six delay-line cells (one row or one plane each, one RAM port pair per
// cell), so throughput is one word per cycle unless the output stalls. A
// result belongs to the word accepted 3*sx*sy + 3*sx + 3 words earlier; after
// the last real voxel the host sends pad words until the word flagged last
// comes out. A full output register holds the whole pipe. A size write
// restarts the volume; the new size takes effect through the registered sx,
// sy, sz, plane, total and lag values.
module gaussian_smooth_max_3d #(
    parameter int MAX_DIM   = gsm3_pkg::MAX_DIM_DEF,
    parameter int COEF_BITS = gsm3_pkg::COEF_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  gsm3_pkg::in_word_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output gsm3_pkg::out_word_t        out_data,
    input  logic                       cfg_we,
    input  logic [gsm3_pkg::IDX_W-1:0] cfg_index,
    input  logic [gsm3_pkg::CFG_W-1:0] cfg_data
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int PL_W   = 2 * DIM_W;
    localparam int POS_W  = 3 * DIM_W + 1;
    localparam int LAST_S = 18;
    localparam int RS     = (gsm3_pkg::SIZE_RESET > MAX_DIM) ? MAX_DIM
                                                              : gsm3_pkg::SIZE_RESET;
    localparam int R_PLANE = RS * RS;
    localparam int R_TOT   = R_PLANE * RS;
    localparam int R_LAGY  = 3 * RS + 3;
    localparam int R_LAGZ  = 3 * R_PLANE + R_LAGY;

    typedef struct packed {
        logic             vld;
        logic             xv;
        logic             yv;
        logic             zv;
        logic             last;
        logic [DIM_W-1:0] qx;
        logic [DIM_W-1:0] syc;
        logic [DIM_W-1:0] uz;
    } ctl_t;

    typedef logic [gsm3_pkg::TAPS-1:0][gsm3_pkg::PIX_W-1:0] pix_taps_t;
    typedef logic [gsm3_pkg::TAPS-1:0][gsm3_pkg::WORD_W-1:0] word_taps_t;

    function automatic logic [DIM_W-1:0] eff_size(input logic [gsm3_pkg::CFG_W-1:0] r);
        if (r == '0)
        begin
            return DIM_W'(1);
        end
        if (int'(r) > MAX_DIM)
        begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(r);
    endfunction

    logic [gsm3_pkg::CFG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [DIM_W-1:0]           sx_reg, sy_reg, sz_reg;
    logic [PL_W-1:0]            plane_reg;
    logic [POS_W-1:0]           tot_reg, lagy_reg, lagz_reg;
    logic [POS_W-1:0]           tot_x_reg, tot_y_reg, tot_z_reg;
    logic                       clear;

    logic [POS_W-1:0] t_reg, t_next;
    logic [DIM_W-1:0] qx_reg, qx_next;
    logic [DIM_W-1:0] sxc_reg, sxc_next, syc_reg, syc_next;
    logic [DIM_W-1:0] ux_reg, ux_next, uy_reg, uy_next, uz_reg, uz_next;

    logic      en, accept, push, tick;
    ctl_t      c0;
    ctl_t      ctl_reg [0:LAST_S];
    pix_taps_t x_taps_reg;

    logic [gsm3_pkg::PIX_W-1:0] orig1_reg, orig2_reg, orig9_reg, orig10_reg;
    logic [gsm3_pkg::PIX_W-1:0] orig17_reg, orig18_reg;
    logic [gsm3_pkg::PIX_W-1:0] xres, yres, zres, vmax;
    word_taps_t                 row_taps, plane_taps;
    pix_taps_t                  row_pix, plane_pix;

    logic                out_valid_reg;
    gsm3_pkg::out_word_t out_data_reg;

    // configuration
    always_comb
    begin
        clear = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                gsm3_pkg::REG_SIZE_X,
                gsm3_pkg::REG_SIZE_Y,
                gsm3_pkg::REG_SIZE_Z: clear = 1'b1;
                default:              clear = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= gsm3_pkg::CFG_W'(gsm3_pkg::SIZE_RESET);
            size_y_reg <= gsm3_pkg::CFG_W'(gsm3_pkg::SIZE_RESET);
            size_z_reg <= gsm3_pkg::CFG_W'(gsm3_pkg::SIZE_RESET);
            sx_reg     <= DIM_W'(RS);
            sy_reg     <= DIM_W'(RS);
            sz_reg     <= DIM_W'(RS);
            plane_reg  <= PL_W'(R_PLANE);
            tot_reg    <= POS_W'(R_TOT);
            lagy_reg   <= POS_W'(R_LAGY);
            lagz_reg   <= POS_W'(R_LAGZ);
            tot_x_reg  <= POS_W'(R_TOT + 3);
            tot_y_reg  <= POS_W'(R_TOT + R_LAGY);
            tot_z_reg  <= POS_W'(R_TOT + R_LAGZ);
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gsm3_pkg::REG_SIZE_X: size_x_reg <= cfg_data;
                    gsm3_pkg::REG_SIZE_Y: size_y_reg <= cfg_data;
                    gsm3_pkg::REG_SIZE_Z: size_z_reg <= cfg_data;
                    default:              ;
                endcase
            end
            sx_reg    <= eff_size(size_x_reg);
            sy_reg    <= eff_size(size_y_reg);
            sz_reg    <= eff_size(size_z_reg);
            plane_reg <= PL_W'(sx_reg) * PL_W'(sy_reg);
            tot_reg   <= POS_W'(plane_reg) * POS_W'(sz_reg);
            lagy_reg  <= POS_W'(sx_reg) * POS_W'(3) + POS_W'(3);
            lagz_reg  <= POS_W'(plane_reg) * POS_W'(3) + lagy_reg;
            tot_x_reg <= tot_reg + POS_W'(3);
            tot_y_reg <= tot_reg + lagy_reg;
            tot_z_reg <= tot_reg + lagz_reg;
        end
    end

    // input side position tracking
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign accept   = in_valid && en;
    assign push     = t_reg >= tot_reg;
    assign tick     = accept && (push || !in_data.pad);

    always_comb
    begin
        c0.vld  = tick;
        c0.xv   = (t_reg >= POS_W'(3)) && (t_reg < tot_x_reg);
        c0.yv   = (t_reg >= lagy_reg) && (t_reg < tot_y_reg);
        c0.zv   = (t_reg >= lagz_reg) && (t_reg < tot_z_reg);
        c0.last = c0.zv && ((t_reg + POS_W'(1)) == tot_z_reg);
        c0.qx   = qx_reg;
        c0.syc  = syc_reg;
        c0.uz   = uz_reg;

        t_next   = t_reg;
        qx_next  = qx_reg;
        sxc_next = sxc_reg;
        syc_next = syc_reg;
        ux_next  = ux_reg;
        uy_next  = uy_reg;
        uz_next  = uz_reg;

        if (clear || (tick && c0.last))
        begin
            t_next   = '0;
            qx_next  = '0;
            sxc_next = '0;
            syc_next = '0;
            ux_next  = '0;
            uy_next  = '0;
            uz_next  = '0;
        end
        else if (tick)
        begin
            t_next = t_reg + POS_W'(1);
            if (c0.xv)
            begin
                qx_next = (qx_reg == sx_reg - DIM_W'(1)) ? '0 : qx_reg + DIM_W'(1);
            end
            if (c0.yv)
            begin
                if (sxc_reg == sx_reg - DIM_W'(1))
                begin
                    sxc_next = '0;
                    syc_next = (syc_reg == sy_reg - DIM_W'(1)) ? '0
                                                                : syc_reg + DIM_W'(1);
                end
                else
                begin
                    sxc_next = sxc_reg + DIM_W'(1);
                end
            end
            if (c0.zv)
            begin
                if (ux_reg == sx_reg - DIM_W'(1))
                begin
                    ux_next = '0;
                    if (uy_reg == sy_reg - DIM_W'(1))
                    begin
                        uy_next = '0;
                        uz_next = uz_reg + DIM_W'(1);
                    end
                    else
                    begin
                        uy_next = uy_reg + DIM_W'(1);
                    end
                end
                else
                begin
                    ux_next = ux_reg + DIM_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg      <= '0;
            qx_reg     <= '0;
            sxc_reg    <= '0;
            syc_reg    <= '0;
            ux_reg     <= '0;
            uy_reg     <= '0;
            uz_reg     <= '0;
            x_taps_reg <= '0;
            for (int s = 0; s <= LAST_S; s++)
            begin
                ctl_reg[s] <= '0;
            end
        end
        else
        begin
            t_reg   <= t_next;
            qx_reg  <= qx_next;
            sxc_reg <= sxc_next;
            syc_reg <= syc_next;
            ux_reg  <= ux_next;
            uy_reg  <= uy_next;
            uz_reg  <= uz_next;
            if (tick)
            begin
                x_taps_reg <= {x_taps_reg[gsm3_pkg::TAPS-2:0],
                               push ? gsm3_pkg::PIX_W'(0) : in_data.voxel_in};
            end
            if (en)
            begin
                ctl_reg[0] <= c0;
                for (int s = 1; s <= LAST_S; s++)
                begin
                    ctl_reg[s] <= ctl_reg[s-1];
                end
            end
        end
    end

    // x pass
    gsm3_pass #(
        .DIM_W     (DIM_W),
        .COEF_BITS (COEF_BITS)
    ) u_pass_x (
        .clk  (clk),
        .en   (en),
        .taps (x_taps_reg),
        .pos  (ctl_reg[0].qx),
        .size (sx_reg),
        .res  (xres)
    );

    // row cells
    gsm3_chain #(
        .DEPTH (MAX_DIM),
        .LEN_W (DIM_W)
    ) u_row_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .clear (clear),
        .len   (sx_reg),
        .vld   (ctl_reg[2].vld),
        .din   ({orig2_reg, xres}),
        .taps  (row_taps)
    );

    always_comb
    begin
        for (int k = 0; k < gsm3_pkg::TAPS; k++)
        begin
            row_pix[k]   = row_taps[k][gsm3_pkg::PIX_W-1:0];
            plane_pix[k] = plane_taps[k][gsm3_pkg::PIX_W-1:0];
        end
    end

    // y pass
    gsm3_pass #(
        .DIM_W     (DIM_W),
        .COEF_BITS (COEF_BITS)
    ) u_pass_y (
        .clk  (clk),
        .en   (en),
        .taps (row_pix),
        .pos  (ctl_reg[8].syc),
        .size (sy_reg),
        .res  (yres)
    );

    // plane cells
    gsm3_chain #(
        .DEPTH (MAX_DIM * MAX_DIM),
        .LEN_W (PL_W)
    ) u_plane_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .clear (clear),
        .len   (plane_reg),
        .vld   (ctl_reg[10].vld),
        .din   ({orig10_reg, yres}),
        .taps  (plane_taps)
    );

    // z pass
    gsm3_pass #(
        .DIM_W     (DIM_W),
        .COEF_BITS (COEF_BITS)
    ) u_pass_z (
        .clk  (clk),
        .en   (en),
        .taps (plane_pix),
        .pos  (ctl_reg[16].uz),
        .size (sz_reg),
        .res  (zres)
    );

    // original voxel rides along the center taps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            orig1_reg  <= x_taps_reg[gsm3_pkg::RADIUS];
            orig2_reg  <= orig1_reg;
            orig9_reg  <= row_taps[gsm3_pkg::RADIUS][gsm3_pkg::WORD_W-1:gsm3_pkg::PIX_W];
            orig10_reg <= orig9_reg;
            orig17_reg <= plane_taps[gsm3_pkg::RADIUS][gsm3_pkg::WORD_W-1:gsm3_pkg::PIX_W];
            orig18_reg <= orig17_reg;
        end
    end

    assign vmax = (orig18_reg > zres) ? orig18_reg : zres;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= ctl_reg[LAST_S].vld && ctl_reg[LAST_S].zv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && ctl_reg[LAST_S].vld && ctl_reg[LAST_S].zv)
        begin
            out_data_reg.voxel_out <= vmax;
            out_data_reg.last      <= ctl_reg[LAST_S].last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
